// ----- src/bnf_pkg.sv -----
// shared types and constants of the batch norm forward core
package bnf_pkg;

    localparam int CH_W  = 11;
    localparam int POS_W = 18;
    localparam int ROW_W = 7;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

    localparam logic [1:0] TB_SCALE = 2'd0;
    localparam logic [1:0] TB_BIAS  = 2'd1;
    localparam logic [1:0] TB_MEAN  = 2'd2;
    localparam logic [1:0] TB_VAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNSUP = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_BATCH    = 3'd1;
    localparam logic [2:0] CFG_CHANNELS = 3'd2;
    localparam logic [2:0] CFG_SPATIAL  = 3'd3;
    localparam logic [2:0] CFG_MOMENTUM = 3'd4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [31:0] EPS_Q   = 32'd17;

    typedef enum logic [2:0] {
        K_WRITE,
        K_READ,
        K_NORM_RUN,
        K_NORM_BAT,
        K_LOAD,
        K_ERR
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [1:0]         sel;
        logic [9:0]         idx;
        logic [CH_W-1:0]    ch;
        logic [POS_W-1:0]   addr;
        logic signed [31:0] value;
        logic               last;
        logic [1:0]         status;
        logic               finish;
        logic [ROW_W-1:0]   rows;
        logic [CH_W-1:0]    cols;
    } t_cmd;

endpackage

// ----- src/bnf_in_if.sv -----
// input item channel
interface bnf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [1:0]         table_select;
    logic [9:0]         channel_index;
    logic signed [31:0] value;

    modport source(output valid, operation, table_select, channel_index, value, input ready);
    modport sink(input valid, operation, table_select, channel_index, value, output ready);
endinterface

// ----- src/bnf_out_if.sv -----
// result item channel
interface bnf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               last;
    logic [1:0]         status;

    modport source(output valid, result_value, last, status, input ready);
    modport sink(input valid, result_value, last, status, output ready);
endinterface

// ----- src/bnf_ram.sv -----
// generic single write port ram with registered read
module bnf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/bnf_fifo.sv -----
// short command queue between front and back
module bnf_fifo import bnf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
endmodule

// ----- src/bnf_front.sv -----
// front end: config registers, positions and item classification
module bnf_front import bnf_pkg::*; #(
    parameter int MAX_CHANNELS = 1024,
    parameter int BUFFER_DEPTH = 4096,
    parameter int MAX_BATCH    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    bnf_in_if.sink      i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd,
    output logic [16:0] o_momentum
);
    logic              r_mode;
    logic [6:0]        r_batch;
    logic [10:0]       r_channels;
    logic [12:0]       r_spatial;
    logic [16:0]       r_momentum;

    logic [12:0]       r_sp;
    logic [CH_W-1:0]   r_ch;
    logic [POS_W-1:0]  r_pos;
    logic              r_rdy;
    logic [POS_W-1:0]  r_fpos;
    logic [CH_W-1:0]   r_fcol;
    logic [CH_W-1:0]   r_rcols;
    logic [POS_W-1:0]  r_rtotal;

    logic [CH_W-1:0]   cols;
    logic [12:0]       spat;
    logic [ROW_W-1:0]  rows;
    logic [POS_W-1:0]  total;
    logic              accept;
    logic              inf_last;
    logic              tr_bad;
    logic              tr_fin;
    logic              f_err;
    logic              f_last;
    logic              idx_ok;
    t_cmd              cmd;

    always_comb begin
        if (r_channels == '0) begin
            cols = CH_W'(1);
        end else if (32'(r_channels) > MAX_CHANNELS) begin
            cols = CH_W'(MAX_CHANNELS);
        end else begin
            cols = r_channels;
        end
        spat = (r_spatial == '0) ? 13'd1 : r_spatial;
        if (r_batch == '0) begin
            rows = ROW_W'(1);
        end else if (32'(r_batch) > MAX_BATCH) begin
            rows = ROW_W'(MAX_BATCH);
        end else begin
            rows = r_batch;
        end
    end

    assign total    = POS_W'(rows) * POS_W'(cols);
    assign accept   = i_in.valid && i_in.ready;
    assign idx_ok   = 32'(i_in.channel_index) < MAX_CHANNELS;
    assign inf_last = (r_ch == cols - 1'b1) && (r_sp == spat - 1'b1);
    assign tr_bad   = (r_spatial != 13'd1) || (32'(total) > BUFFER_DEPTH);
    assign tr_fin   = (r_pos == total - 1'b1);
    assign f_err    = !r_rdy || (r_fpos >= r_rtotal);
    assign f_last   = (r_fpos == r_rtotal - 1'b1);

    always_comb begin
        cmd        = '0;
        cmd.kind   = K_ERR;
        cmd.sel    = i_in.table_select;
        cmd.idx    = i_in.channel_index;
        cmd.value  = i_in.value;
        cmd.rows   = rows;
        cmd.cols   = cols;
        cmd.status = ST_OK;
        case (i_in.operation)
            OP_WRITE: begin
                cmd.kind = K_WRITE;
            end
            OP_READ: begin
                cmd.kind = idx_ok ? K_READ : K_ERR;
            end
            OP_DATA: begin
                if (!r_mode) begin
                    cmd.kind = K_NORM_RUN;
                    cmd.ch   = r_ch;
                    cmd.last = inf_last;
                end else if (tr_bad) begin
                    cmd.kind   = K_ERR;
                    cmd.status = ST_UNSUP;
                end else begin
                    cmd.kind   = K_LOAD;
                    cmd.addr   = r_pos;
                    cmd.finish = tr_fin;
                end
            end
            OP_FETCH: begin
                if (f_err) begin
                    cmd.kind   = K_ERR;
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.kind = K_NORM_BAT;
                    cmd.addr = r_fpos;
                    cmd.ch   = r_fcol;
                    cmd.last = f_last;
                end
            end
            default: begin
                cmd.kind = K_ERR;
            end
        endcase
    end

    assign i_in.ready = !i_full;
    assign o_push     = accept && !(i_in.operation == OP_WRITE && !idx_ok);
    assign o_cmd      = cmd;
    assign o_momentum = (r_momentum > ONE_Q16) ? ONE_Q16 : r_momentum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_batch    <= 7'd1;
            r_channels <= 11'd1;
            r_spatial  <= 13'd1;
            r_momentum <= '0;
            r_sp       <= '0;
            r_ch       <= '0;
            r_pos      <= '0;
            r_rdy      <= 1'b0;
            r_fpos     <= '0;
            r_fcol     <= '0;
            r_rcols    <= '0;
            r_rtotal   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:     r_mode     <= i_cfg_data[0];
                    CFG_BATCH:    r_batch    <= i_cfg_data[6:0];
                    CFG_CHANNELS: r_channels <= i_cfg_data[10:0];
                    CFG_SPATIAL:  r_spatial  <= i_cfg_data[12:0];
                    CFG_MOMENTUM: r_momentum <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= CFG_MOMENTUM) begin
                    r_sp  <= '0;
                    r_ch  <= '0;
                    r_pos <= '0;
                end
            end
            if (accept) begin
                if (i_in.operation == OP_DATA && !r_mode) begin
                    if (inf_last) begin
                        r_sp <= '0;
                        r_ch <= '0;
                    end else if (r_sp == spat - 1'b1) begin
                        r_sp <= '0;
                        r_ch <= r_ch + 1'b1;
                    end else begin
                        r_sp <= r_sp + 1'b1;
                    end
                end else if (i_in.operation == OP_DATA && !tr_bad) begin
                    if (r_pos == '0) begin
                        r_rdy <= 1'b0;
                    end
                    if (tr_fin) begin
                        r_pos    <= '0;
                        r_rdy    <= 1'b1;
                        r_fpos   <= '0;
                        r_fcol   <= '0;
                        r_rcols  <= cols;
                        r_rtotal <= total;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end else if (i_in.operation == OP_FETCH && !f_err) begin
                    if (f_last) begin
                        r_rdy  <= 1'b0;
                        r_fpos <= '0;
                    end else begin
                        r_fpos <= r_fpos + 1'b1;
                    end
                    r_fcol <= (r_fcol == r_rcols - 1'b1) ? '0 : r_fcol + 1'b1;
                end
            end
        end
    end
endmodule

// ----- src/bnf_div.sv -----
// radix-2 restoring divider, 64 by 32 bits, one quotient bit per cycle
module bnf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[63]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ----- src/bnf_back.sv -----
// back end: tables, batch buffer, normalize datapath and batch statistics
module bnf_back import bnf_pkg::*; #(
    parameter int MAX_CHANNELS = 1024,
    parameter int BUFFER_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_cmd,
    output logic        o_q_pop,
    input  logic [16:0] i_momentum,
    bnf_out_if.source   o_out
);
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE, S_LOOK, S_SQRT, S_DIV, S_MUL, S_RND, S_EMIT,
        F_SRD, F_SACC, F_MDIV, F_VRD, F_VMUL, F_VACC, F_VDIV, F_B1, F_B2, F_B3
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic signed [31:0]  r_x, r_mean, r_var, r_scale, r_bias;
    logic [55:0]         r_rad;
    logic [29:0]         r_rem;
    logic [27:0]         r_root;
    logic [4:0]          r_it;
    logic                r_neg;
    logic signed [31:0]  r_norm;
    logic                r_sat;
    logic signed [63:0]  r_prod;
    logic signed [31:0]  r_res;
    logic                r_last;
    logic [1:0]          r_status;
    logic [CH_W-1:0]     r_col;
    logic [ROW_W-1:0]    r_row;
    logic [POS_W-1:0]    r_faddr;
    logic signed [38:0]  r_sum;
    logic [63:0]         r_msq;
    logic [47:0]         r_sq;
    logic signed [49:0]  r_p1, r_p2;
    logic                r_dstart;
    logic [63:0]         r_dnum;
    logic [31:0]         r_dden;
    logic                r_ovalid;
    logic signed [31:0]  r_oval;
    logic                r_olast;
    logic [1:0]          r_ostat;

    logic                pop;
    logic [CW-1:0]       t_raddr;
    logic [BW-1:0]       b_raddr;
    logic signed [31:0]  scale_rd, bias_rd, rmean_rd, rvar_rd, bmean_rd, bvar_rd, buf_rd;
    logic                scale_we, bias_we, rmean_we, rvar_we, buf_we, bstat_we;
    logic [CW-1:0]       rm_waddr, rv_waddr;
    logic signed [31:0]  rm_wdata, rv_wdata;
    logic                div_done;
    logic [63:0]         div_quo;
    logic [31:0]         sq_t;
    logic                sq_ge;
    logic [27:0]         sq_root_n;
    logic [29:0]         sq_rem_n;
    logic signed [32:0]  diff;
    logic [32:0]         diff_mag;
    logic signed [32:0]  vdiff;
    logic [31:0]         vmag;
    logic signed [38:0]  sum_new;
    logic [38:0]         sum_mag;
    logic [47:0]         sq_new;
    logic [64:0]         sq_term;
    logic signed [31:0]  blend_res;
    logic [16:0]         one_m;
    logic [31:0]         norm_mag;
    logic                norm_sat;
    logic signed [31:0]  norm_val;
    logic signed [65:0]  rnd_sum;
    logic signed [31:0]  rnd_res;
    logic                rnd_sat;
    logic signed [31:0]  tbl_rd;

    function automatic logic signed [31:0] blend16(input logic signed [50:0] a);
        logic [50:0]        mag;
        logic [50:0]        q;
        logic signed [51:0] v;
        begin
            mag = a[50] ? 51'(-a) : 51'(a);
            q   = (mag + 51'h8000) >> 16;
            v   = a[50] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (v > 52'sd2147483647) begin
                blend16 = 32'sh7fffffff;
            end else if (v < -52'sd2147483648) begin
                blend16 = 32'sh80000000;
            end else begin
                blend16 = v[31:0];
            end
        end
    endfunction

    assign pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop = pop;

    assign t_raddr = (r_state == S_IDLE) ?
                     ((i_cmd.kind == K_READ) ? CW'(i_cmd.idx) : CW'(i_cmd.ch)) : CW'(r_col);
    assign b_raddr = (r_state == S_IDLE) ? BW'(i_cmd.addr) : BW'(r_faddr);

    assign scale_we = pop && i_cmd.kind == K_WRITE && i_cmd.sel == TB_SCALE;
    assign bias_we  = pop && i_cmd.kind == K_WRITE && i_cmd.sel == TB_BIAS;
    assign rmean_we = (pop && i_cmd.kind == K_WRITE && i_cmd.sel == TB_MEAN) || r_state == F_B2;
    assign rvar_we  = (pop && i_cmd.kind == K_WRITE && i_cmd.sel == TB_VAR) || r_state == F_B3;
    assign buf_we   = pop && i_cmd.kind == K_LOAD;
    assign bstat_we = (r_state == F_B3);
    assign rm_waddr = pop ? CW'(i_cmd.idx) : CW'(r_col);
    assign rv_waddr = pop ? CW'(i_cmd.idx) : CW'(r_col);
    assign rm_wdata = pop ? i_cmd.value : blend_res;
    assign rv_wdata = pop ? i_cmd.value : blend_res;

    bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_scale (
        .i_clk(i_clk), .i_we(scale_we), .i_waddr(CW'(i_cmd.idx)), .i_wdata(i_cmd.value),
        .i_raddr(t_raddr), .o_rdata(scale_rd));
    bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_bias (
        .i_clk(i_clk), .i_we(bias_we), .i_waddr(CW'(i_cmd.idx)), .i_wdata(i_cmd.value),
        .i_raddr(t_raddr), .o_rdata(bias_rd));
    bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_rmean (
        .i_clk(i_clk), .i_we(rmean_we), .i_waddr(rm_waddr), .i_wdata(rm_wdata),
        .i_raddr(t_raddr), .o_rdata(rmean_rd));
    bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_rvar (
        .i_clk(i_clk), .i_we(rvar_we), .i_waddr(rv_waddr), .i_wdata(rv_wdata),
        .i_raddr(t_raddr), .o_rdata(rvar_rd));
    bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_bmean (
        .i_clk(i_clk), .i_we(bstat_we), .i_waddr(CW'(r_col)), .i_wdata(r_mean),
        .i_raddr(t_raddr), .o_rdata(bmean_rd));
    bnf_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_bvar (
        .i_clk(i_clk), .i_we(bstat_we), .i_waddr(CW'(r_col)), .i_wdata(r_var),
        .i_raddr(t_raddr), .o_rdata(bvar_rd));
    bnf_ram #(.WIDTH(32), .DEPTH(BUFFER_DEPTH)) u_buf (
        .i_clk(i_clk), .i_we(buf_we), .i_waddr(BW'(i_cmd.addr)), .i_wdata(i_cmd.value),
        .i_raddr(b_raddr), .o_rdata(buf_rd));

    bnf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_dnum),
        .i_den(r_dden), .o_done(div_done), .o_quo(div_quo));

    // square root step
    assign sq_t      = {r_rem, r_rad[55:54]};
    assign sq_ge     = sq_t >= {r_root, 2'b01};
    assign sq_root_n = {r_root[26:0], sq_ge};
    assign sq_rem_n  = sq_ge ? 30'(sq_t - {r_root, 2'b01}) : sq_t[29:0];

    assign diff     = 33'(r_x) - 33'(r_mean);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    assign vdiff   = 33'(buf_rd) - 33'(r_mean);
    assign vmag    = vdiff[32] ? 32'(-vdiff) : 32'(vdiff);
    assign sum_new = r_sum + 39'(buf_rd);
    assign sum_mag = sum_new[38] ? 39'(-sum_new) : 39'(sum_new);
    assign sq_term = (65'(r_msq) + 65'h800000) >> 24;
    assign sq_new  = r_sq + 48'(sq_term);

    assign blend_res = blend16(51'(r_p1) + 51'(r_p2));
    assign one_m     = ONE_Q16 - i_momentum;

    always_comb begin
        if (r_neg) begin
            norm_sat = div_quo > 64'h80000000;
            norm_mag = norm_sat ? 32'h80000000 : div_quo[31:0];
            norm_val = 32'(-$signed({1'b0, norm_mag}));
        end else begin
            norm_sat = div_quo > 64'h7fffffff;
            norm_mag = norm_sat ? 32'h7fffffff : div_quo[31:0];
            norm_val = $signed(norm_mag);
        end
    end

    always_comb begin
        logic [64:0] mag;
        logic [64:0] q;
        mag     = r_prod[63] ? 65'(-r_prod) : 65'(r_prod);
        q       = (mag + 65'h800000) >> 24;
        rnd_sum = (r_prod[63] ? -$signed({1'b0, q}) : $signed({1'b0, q})) + 66'(r_bias);
        if (rnd_sum > 66'sd2147483647) begin
            rnd_res = 32'sh7fffffff;
            rnd_sat = 1'b1;
        end else if (rnd_sum < -66'sd2147483648) begin
            rnd_res = 32'sh80000000;
            rnd_sat = 1'b1;
        end else begin
            rnd_res = rnd_sum[31:0];
            rnd_sat = 1'b0;
        end
    end

    always_comb begin
        case (r_cmd.sel)
            TB_SCALE: tbl_rd = scale_rd;
            TB_BIAS:  tbl_rd = bias_rd;
            TB_MEAN:  tbl_rd = rmean_rd;
            default:  tbl_rd = rvar_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.kind)
                            K_WRITE: r_state <= S_IDLE;
                            K_LOAD: begin
                                if (i_cmd.finish) begin
                                    r_col   <= '0;
                                    r_row   <= '0;
                                    r_faddr <= '0;
                                    r_sum   <= '0;
                                    r_state <= F_SRD;
                                end
                            end
                            K_ERR: begin
                                r_res    <= '0;
                                r_last   <= 1'b0;
                                r_status <= i_cmd.status;
                                r_state  <= S_EMIT;
                            end
                            default: r_state <= S_LOOK;
                        endcase
                    end
                end
                S_LOOK: begin
                    if (r_cmd.kind == K_READ) begin
                        r_res    <= tbl_rd;
                        r_last   <= 1'b0;
                        r_status <= ST_OK;
                        r_state  <= S_EMIT;
                    end else begin
                        r_x     <= (r_cmd.kind == K_NORM_RUN) ? r_cmd.value : buf_rd;
                        r_mean  <= (r_cmd.kind == K_NORM_RUN) ? rmean_rd : bmean_rd;
                        r_var   <= (r_cmd.kind == K_NORM_RUN) ? rvar_rd : bvar_rd;
                        r_scale <= scale_rd;
                        r_bias  <= bias_rd;
                        if (r_cmd.kind == K_NORM_RUN) begin
                            r_rad <= {1'b0, (rvar_rd[31] ? 31'd0 : rvar_rd[30:0]), 24'd0};
                        end else begin
                            r_rad <= {1'b0, (bvar_rd[31] ? 31'd0 : bvar_rd[30:0]), 24'd0};
                        end
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_it    <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_rad  <= {r_rad[53:0], 2'b00};
                    r_rem  <= sq_rem_n;
                    r_root <= sq_root_n;
                    r_it   <= r_it + 1'b1;
                    if (r_it == 5'd27) begin
                        r_dnum   <= 64'(diff_mag) << 24;
                        r_dden   <= 32'(sq_root_n) + EPS_Q;
                        r_neg    <= diff[32];
                        r_dstart <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_norm  <= norm_val;
                        r_sat   <= norm_sat;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_norm * r_scale;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_res    <= rnd_res;
                    r_last   <= r_cmd.last;
                    r_status <= (r_sat || rnd_sat) ? ST_SAT : ST_OK;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_res;
                        r_olast  <= r_last;
                        r_ostat  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                F_SRD: begin
                    r_state <= F_SACC;
                end
                F_SACC: begin
                    r_sum   <= sum_new;
                    r_faddr <= r_faddr + POS_W'(r_cmd.cols);
                    r_row   <= r_row + 1'b1;
                    if (r_row == r_cmd.rows - 1'b1) begin
                        r_dnum   <= 64'(sum_mag);
                        r_dden   <= 32'(r_cmd.rows);
                        r_dstart <= 1'b1;
                        r_state  <= F_MDIV;
                    end else begin
                        r_state <= F_SRD;
                    end
                end
                F_MDIV: begin
                    if (div_done) begin
                        r_mean  <= r_sum[38] ? 32'(-$signed({1'b0, div_quo[31:0]}))
                                             : $signed(div_quo[31:0]);
                        r_row   <= '0;
                        r_faddr <= POS_W'(r_col);
                        r_sq    <= '0;
                        r_state <= F_VRD;
                    end
                end
                F_VRD: begin
                    r_state <= F_VMUL;
                end
                F_VMUL: begin
                    r_msq   <= 64'(vmag) * 64'(vmag);
                    r_state <= F_VACC;
                end
                F_VACC: begin
                    r_sq    <= sq_new;
                    r_faddr <= r_faddr + POS_W'(r_cmd.cols);
                    r_row   <= r_row + 1'b1;
                    if (r_row == r_cmd.rows - 1'b1) begin
                        r_dnum   <= 64'(sq_new);
                        r_dden   <= 32'(r_cmd.rows);
                        r_dstart <= 1'b1;
                        r_state  <= F_VDIV;
                    end else begin
                        r_state <= F_VRD;
                    end
                end
                F_VDIV: begin
                    if (div_done) begin
                        r_var   <= (div_quo > 64'h7fffffff) ? 32'sh7fffffff
                                                            : $signed(div_quo[31:0]);
                        r_state <= F_B1;
                    end
                end
                F_B1: begin
                    r_p1    <= rmean_rd * $signed({1'b0, one_m});
                    r_p2    <= r_mean * $signed({1'b0, i_momentum});
                    r_state <= F_B2;
                end
                F_B2: begin
                    r_p1    <= rvar_rd * $signed({1'b0, one_m});
                    r_p2    <= r_var * $signed({1'b0, i_momentum});
                    r_state <= F_B3;
                end
                F_B3: begin
                    if (r_col == r_cmd.cols - 1'b1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_row   <= '0;
                        r_faddr <= POS_W'(r_col) + 1'b1;
                        r_sum   <= '0;
                        r_state <= F_SRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_oval;
    assign o_out.last         = r_olast;
    assign o_out.status       = r_ostat;
endmodule

// ----- src/batch_norm_forward_core.sv -----
// top level of the batch norm forward core
//
//  port          dir  kind        fields
//  i_in          in   valid/ready operation, table_select, channel_index, value
//  o_out         out  valid/ready result_value, last, status
//  i_cfg_*       in   write only  i_cfg_we, i_cfg_index, i_cfg_data
//
//  table write: taken in S_IDLE on the pop; table read: looked up in S_LOOK, then emitted
//  normalize (inference element or fetch): runs the 28-step square root, then the
//  shared divider, a multiply and a rounding step
//  batch finish: per column two buffer passes and two divides, then the blend
//  synchronous active-low reset; no clearing pass, the tables start unwritten
//  a 4-entry command queue lets the front keep taking beats while the back stalls
module batch_norm_forward_core import bnf_pkg::*; #(
    parameter int MAX_CHANNELS = 1024,
    parameter int BUFFER_DEPTH = 4096,
    parameter int MAX_BATCH    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    bnf_in_if.sink      i_in,
    bnf_out_if.source   o_out
);
    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    t_cmd        push_cmd;
    t_cmd        q_cmd;
    logic [16:0] momentum;

    bnf_front #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .MAX_BATCH(MAX_BATCH)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in(i_in), .i_full(full), .o_push(push), .o_cmd(push_cmd),
        .o_momentum(momentum));

    bnf_fifo #(.DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(push_cmd),
        .o_full(full), .i_pop(pop), .o_valid(q_valid), .o_cmd(q_cmd));

    bnf_back #(
        .MAX_CHANNELS(MAX_CHANNELS),
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_cmd(q_cmd),
        .o_q_pop(pop), .i_momentum(momentum), .o_out(o_out));
endmodule

// ----- sim/tb_batch_norm_forward_core.sv -----
// self-checking testbench of the batch norm forward core with its own predictor
module tb_batch_norm_forward_core;
    import bnf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         op;
        logic [1:0]         sel;
        logic [9:0]         idx;
        logic signed [31:0] value;
    } beat_t;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic [1:0]         status;
    } norm_res_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    bnf_in_if  in_if();
    bnf_out_if out_if();

    batch_norm_forward_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    int    scale_t[1024], bias_t[1024], rmean_t[1024], rvar_t[1024];
    int    bbuf[4096], bmean[1024], bvar[1024];
    int    load_pos, fetch_pos, ready_cols, ready_total;
    bit    outs_ready;
    int    cfg_mode, cfg_rows, cfg_chan, cfg_spat, cfg_mom;
    logic  norm_sat;
    bit    wrote[4][1024];

    beat_t     pend_q[$];
    norm_res_t result_q[$];
    int        send_idle_pct, recv_stall_pct;
    bit        hold_armed, hold_done;
    int        hold_cnt;
    int        errors, n_beats, n_results, n_batches;

    function automatic longint unsigned sqrt_floor(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        longint unsigned half = 64'd1 << (s - 1);
        if (v < 0) return -longint'((longint'(-v) + half) >> s);
        return longint'((longint'(v) + half) >> s);
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) begin
            norm_sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            norm_sat = 1'b1;
            return 32'h8000_0000;
        end
        return int'(v);
    endfunction

    function automatic int norm_q(int x, int mu, int vr, int scl, int bias);
        longint unsigned v = vr < 0 ? 0 : longint'(vr);
        longint unsigned d = sqrt_floor(v << 24) + 17;
        longint diff = longint'(x) - longint'(mu);
        bit neg = diff < 0;
        longint unsigned mag = neg ? -diff : diff;
        longint unsigned q = (mag << 24) / d;
        longint n;
        norm_sat = 1'b0;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                norm_sat = 1'b1;
            end
            n = -longint'(q);
        end else begin
            if (q > 64'h7fff_ffff) begin
                q = 64'h7fff_ffff;
                norm_sat = 1'b1;
            end
            n = longint'(q);
        end
        return sat32(rnd_shift(n * longint'(scl), 24) + longint'(bias));
    endfunction

    function automatic int blend_q(int run, int stat, int m);
        longint a = longint'(run) * longint'(65536 - m) + longint'(stat) * longint'(m);
        return sat32(rnd_shift(a, 16));
    endfunction

    function automatic int eff_cols();
        return cfg_chan < 1 ? 1 : (cfg_chan > 1024 ? 1024 : cfg_chan);
    endfunction

    function automatic int eff_rows();
        return cfg_rows < 1 ? 1 : (cfg_rows > 64 ? 64 : cfg_rows);
    endfunction

    function automatic void close_batch(int rows, int cols);
        int m = cfg_mom > 65536 ? 65536 : cfg_mom;
        longint sum;
        longint unsigned sq, mag, vv;
        longint dd;
        int mu;
        for (int c = 0; c < cols; c++) begin
            sum = 0;
            sq = 0;
            for (int r = 0; r < rows; r++) sum += bbuf[r * cols + c];
            mu = int'(sum / rows);
            for (int r = 0; r < rows; r++) begin
                dd = longint'(bbuf[r * cols + c]) - mu;
                mag = dd < 0 ? -dd : dd;
                sq += (mag * mag + (64'd1 << 23)) >> 24;
            end
            vv = sq / rows;
            if (vv > 64'h7fff_ffff) vv = 64'h7fff_ffff;
            bmean[c] = mu;
            bvar[c] = int'(vv);
            rmean_t[c] = blend_q(rmean_t[c], mu, m);
            rvar_t[c] = blend_q(rvar_t[c], int'(vv), m);
        end
    endfunction

    function automatic void predict_beat(beat_t b);
        norm_res_t e = '{value: 0, last: 1'b0, status: ST_OK};
        int cols = eff_cols();
        int spat = cfg_spat < 1 ? 1 : cfg_spat;
        int len, ch, total, c;
        case (b.op)
            OP_WRITE: begin
                case (b.sel)
                    TB_SCALE: scale_t[b.idx] = b.value;
                    TB_BIAS:  bias_t[b.idx] = b.value;
                    TB_MEAN:  rmean_t[b.idx] = b.value;
                    default:  rvar_t[b.idx] = b.value;
                endcase
                return;
            end
            OP_READ: begin
                case (b.sel)
                    TB_SCALE: e.value = scale_t[b.idx];
                    TB_BIAS:  e.value = bias_t[b.idx];
                    TB_MEAN:  e.value = rmean_t[b.idx];
                    default:  e.value = rvar_t[b.idx];
                endcase
            end
            OP_DATA: begin
                if (cfg_mode == 0) begin
                    len = cols * spat;
                    if (load_pos >= len) load_pos = 0;
                    ch = load_pos / spat;
                    e.value = norm_q(b.value, rmean_t[ch], rvar_t[ch], scale_t[ch], bias_t[ch]);
                    e.status = norm_sat ? ST_SAT : ST_OK;
                    e.last = load_pos == len - 1;
                    load_pos = e.last ? 0 : load_pos + 1;
                end else begin
                    total = eff_rows() * cols;
                    if (cfg_spat != 1 || total > 4096) begin
                        e.status = ST_UNSUP;
                    end else begin
                        if (load_pos >= total) load_pos = 0;
                        if (load_pos == 0) outs_ready = 1'b0;
                        bbuf[load_pos] = b.value;
                        load_pos++;
                        if (load_pos == total) begin
                            close_batch(eff_rows(), cols);
                            ready_cols = cols;
                            ready_total = total;
                            fetch_pos = 0;
                            outs_ready = 1'b1;
                            load_pos = 0;
                            n_batches++;
                        end
                        return;
                    end
                end
            end
            default: begin
                if (!outs_ready || ready_cols == 0 || fetch_pos >= ready_total) begin
                    e.status = ST_EMPTY;
                end else begin
                    c = fetch_pos % ready_cols;
                    e.last = fetch_pos == ready_total - 1;
                    e.value = norm_q(bbuf[fetch_pos], bmean[c], bvar[c], scale_t[c], bias_t[c]);
                    e.status = norm_sat ? ST_SAT : ST_OK;
                    if (e.last) begin
                        outs_ready = 1'b0;
                        fetch_pos = 0;
                    end else begin
                        fetch_pos++;
                    end
                end
            end
        endcase
        result_q.push_back(e);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_beat(pend_q.pop_front());
                n_beats++;
            end
            if (!(in_if.valid && !in_if.ready)) begin
                if (pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_if.valid         <= 1'b1;
                    in_if.operation     <= pend_q[0].op;
                    in_if.table_select  <= pend_q[0].sel;
                    in_if.channel_index <= pend_q[0].idx;
                    in_if.value         <= pend_q[0].value;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        norm_res_t e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat value %h last %b status %0d", $time,
                             out_if.result_value, out_if.last, out_if.status);
                end else begin
                    e = result_q.pop_front();
                    if (out_if.result_value !== e.value || out_if.last !== e.last ||
                        out_if.status !== e.status) begin
                        errors++;
                        $display("%0t: expected value %h last %b status %0d, got %h %b %0d",
                                 $time, e.value, e.last, e.status, out_if.result_value,
                                 out_if.last, out_if.status);
                    end
                end
            end
            if (hold_armed && !hold_done) begin
                out_if.ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= 800) hold_done = 1'b1;
            end else begin
                out_if.ready <= $urandom_range(0, 99) >= recv_stall_pct;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, int data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[16:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:     cfg_mode = data & 1;
            CFG_BATCH:    cfg_rows = data & 'h7f;
            CFG_CHANNELS: cfg_chan = data & 'h7ff;
            CFG_SPATIAL:  cfg_spat = data & 'h1fff;
            default:      cfg_mom = data & 'h1ffff;
        endcase
        load_pos = 0;
    endtask

    task automatic set_shape(int mode, int rows, int chans, int spat, int mom);
        cfg_write(CFG_MODE, mode);
        cfg_write(CFG_BATCH, rows);
        cfg_write(CFG_CHANNELS, chans);
        cfg_write(CFG_SPATIAL, spat);
        cfg_write(CFG_MOMENTUM, mom);
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || in_if.valid || result_q.size() > 0) @(posedge i_clk);
        repeat (300 + (cfg_mode ? eff_cols() * (5 * eff_rows() + 140) : 0)) @(posedge i_clk);
    endtask

    function automatic void push(logic [1:0] op, logic [1:0] sel, int idx, int v);
        beat_t b;
        b.op = op;
        b.sel = sel;
        b.idx = idx[9:0];
        b.value = v;
        if (op == OP_WRITE) wrote[sel][idx] = 1'b1;
        pend_q.push_back(b);
    endfunction

    function automatic int rnd_q();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            1: return $urandom;
            default: return int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
        endcase
    endfunction

    function automatic int rnd_table(logic [1:0] sel);
        if ($urandom_range(0, 15) == 0) return $urandom;
        case (sel)
            TB_SCALE: return 32'h0100_0000 + int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            TB_VAR:   return $urandom_range(0, 32'h0800_0000);
            default:  return rnd_q();
        endcase
    endfunction

    function automatic void push_side();
        logic [1:0] sel = $urandom_range(0, 3);
        int idx = $urandom_range(0, 2) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        if ($urandom_range(0, 1)) begin
            push(OP_WRITE, sel, idx, rnd_table(sel));
        end else begin
            if (!wrote[sel][idx]) idx = $urandom_range(0, 15);
            push(OP_READ, sel, idx, $urandom);
        end
    endfunction

    task automatic random_phase(int n);
        int start = pend_q.size() + n_beats;
        int mode, rows, cols, total, nf;
        while (pend_q.size() + n_beats - start < n) begin
            mode = $urandom_range(0, 1);
            rows = $urandom_range(0, 9) == 0 ? 64 : $urandom_range(1, 6);
            cols = rows == 64 ? 1 : $urandom_range(1, mode ? 8 : 16);
            set_shape(mode, rows, cols,
                      mode ? ($urandom_range(0, 19) == 0 ? 2 : 1) :
                      ($urandom_range(0, 19) == 0 ? 4096 : $urandom_range(1, 4)),
                      $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 65536 : 0) :
                      $urandom_range(0, 65536));
            if (mode == 0) begin
                repeat ($urandom_range(20, 50)) begin
                    case ($urandom_range(0, 29))
                        0, 1, 2: push_side();
                        3: push(OP_FETCH, $urandom, $urandom, $urandom);
                        default: push(OP_DATA, $urandom, $urandom, rnd_q());
                    endcase
                end
            end else begin
                total = rows * cols;
                repeat ($urandom_range(1, 3)) begin
                    for (int i = 0; i < total; i++) begin
                        if ($urandom_range(0, 9) == 0) push_side();
                        push(OP_DATA, $urandom, $urandom, rnd_q());
                    end
                    nf = $urandom_range(0, 5) == 0 ? $urandom_range(0, total) :
                         total + ($urandom_range(0, 4) == 0);
                    repeat (nf) push(OP_FETCH, $urandom, $urandom, $urandom);
                end
            end
            drain();
        end
    endtask

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.operation = OP_WRITE;
        in_if.table_select = TB_SCALE;
        in_if.channel_index = '0;
        in_if.value = '0;
        out_if.ready = 1'b0;
        cfg_mode = 0; cfg_rows = 1; cfg_chan = 1; cfg_spat = 1; cfg_mom = 0;
        load_pos = 0; fetch_pos = 0; outs_ready = 1'b0; ready_cols = 0; ready_total = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the tables of the low channels
        for (int c = 0; c < 16; c++)
            for (int s = 0; s < 4; s++)
                push(OP_WRITE, s[1:0], c, s == TB_SCALE ? 32'h0100_0000 :
                     s == TB_VAR ? c * 32'h0010_0000 : c * 32'h0008_0000 - 32'h0040_0000);
        drain();

        // directed corners
        set_shape(0, 1, 4, 1, 0);
        push(OP_WRITE, TB_VAR, 3, 32'h8000_0000);
        push(OP_WRITE, TB_BIAS, 1023, 32'h7fff_ffff);
        push(OP_READ, TB_BIAS, 1023, 0);
        push(OP_READ, TB_VAR, 3, 0);
        push(OP_READ, TB_MEAN, 2, 0);
        push(OP_READ, TB_SCALE, 1, 0);
        push(OP_DATA, 0, 0, 32'h7fff_ffff);
        push(OP_DATA, 0, 0, 32'h8000_0000);
        push(OP_DATA, 0, 0, 0);
        push(OP_DATA, 0, 0, 32'h0123_4567);
        push(OP_FETCH, 0, 0, 0);
        drain();
        set_shape(0, 1, 1, 4096, 65536);
        push(OP_DATA, 0, 0, 32'h7fff_ffff);
        drain();
        set_shape(1, 2, 3, 1, 65536);
        push(OP_FETCH, 0, 0, 0);
        for (int i = 0; i < 6; i++) push(OP_DATA, 0, 0, i * 32'h0300_0000 - 32'h0800_0000);
        repeat (7) push(OP_FETCH, 0, 0, 0);
        drain();
        set_shape(1, 64, 1024, 1, 0);
        push(OP_DATA, 0, 0, 5);
        drain();
        cfg_write(CFG_SPATIAL, 2);
        push(OP_DATA, 0, 0, 5);
        drain();

        // idling phases
        random_phase(180);
        send_idle_pct = 73;
        random_phase(180);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        random_phase(180);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_phase(180);

        // long receiver hold-off while the sender keeps offering, then a full pause
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_shape(0, 1, 16, 1, 0);
        repeat (40) push(OP_DATA, 0, 0, rnd_q());
        hold_armed = 1'b1;
        drain();
        random_phase(100);

        while (pend_q.size() > 0 || in_if.valid || result_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("run covered %0d input beats, %0d result beats, %0d training batches",
                 n_beats, n_results, n_batches);
        $display("inference and training modes under sender gaps and receiver stalls");
        if (errors == 0 && result_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
